[design/lcpsg_pkg.sv]
// ----------------------------------------------------------------------------
// lcpsg_pkg: shared types and constants for the lift cascade controller
// Field widths, loop limits, direction/mode codes and register indexes.
// ----------------------------------------------------------------------------
package lcpsg_pkg;

  // stream word widths
  localparam int IN_DATA_W  = 64;   // 60 payload bits padded to bytes
  localparam int OUT_DATA_W = 40;   // 39 payload bits padded to bytes

  // config port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_OUTER_KI = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OUTER_KD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_KP = 2'd2;

  // field types
  typedef logic signed [20:0] pos_t;
  typedef logic signed [15:0] spd_t;
  typedef logic        [1:0]  code_t;
  typedef logic signed [14:0] drive_t;
  typedef logic signed [21:0] err_t;
  typedef logic signed [22:0] diff_t;

  // direction codes
  localparam code_t DIR_STOP = 2'd0;
  localparam code_t DIR_UP   = 2'd1;
  localparam code_t DIR_DOWN = 2'd2;

  // climb modes
  localparam code_t MODE_NORMAL   = 2'd0;
  localparam code_t MODE_RISING   = 2'd1;
  localparam code_t MODE_LOWERING = 2'd2;

  // limits
  localparam pos_t SP_LO = -21'sd1000;
  localparam pos_t SP_HI = 21'sd810000;
  localparam err_t DIR_BAND = 22'sd100;

  localparam logic signed [22:0] OINT_LIM = 23'sd1000;
  localparam logic signed [22:0] IINT_LIM = 23'sd8000;

  localparam int TGT_MAX   = 1048575;
  localparam int TGT_MIN   = -1048576;
  localparam int DRIVE_LIM = 15000;

  localparam logic [12:0] LIM_UP_NORMAL   = 13'd6000;
  localparam logic [12:0] LIM_UP_LOWERING = 13'd5000;
  localparam logic [12:0] LIM_DN_NORMAL   = 13'd2500;
  localparam logic [12:0] LIM_DN_RISING   = 13'd7000;

  localparam drive_t STALL_DRIVE = 15'sd8000;
  localparam spd_t   DEADBAND    = 16'sd5;

  localparam int STALL_W = 8;

endpackage

[design/lift_cascade_pid_stall_guard_unit.sv]
// ----------------------------------------------------------------------------
// lift_cascade_pid_stall_guard_unit: cascaded position/speed PID for a lift
// Outer position PID, gain schedule, inner speed PID and stall current guard,
// all products computed on one shared multiply-accumulate unit.
// ----------------------------------------------------------------------------
// Usage:
//   s_* : one word per control tick (setpoint, position, speed, climb_mode).
//   m_* : one word per tick back (drive, direction, speed_target, stalled).
//   cfg_*: register writes (outer_ki, outer_kd, inner_kp); write only while
//          the unit is idle. Unknown indexes are ignored.
// Timing:
//   A word is taken in IDLE, then a 16-step sequencer runs: error and
//   integrator, three multiplies for the outer loop, truncating divide,
//   schedule/clamp, speed error and integrator, three multiplies for the
//   inner loop, divide, saturate/stall. A new word is taken only once the
//   sequencer is back in IDLE; the single multiplier (17x23 at the default
//   gain width) serves all six products per word.
// Reset (rst, sync): loop state cleared, gains to their defaults, output
//   register empty. If a held result is unclaimed (m_tready low) when a new
//   one is ready, the sequencer waits in its last step; the next input is
//   taken while a result still sits in the output register.
// ----------------------------------------------------------------------------
module lift_cascade_pid_stall_guard_unit #(
  parameter int GAIN_FRAC_BITS = 8,
  parameter int STALL_TICKS    = 200
) (
  input  logic                                 clk,
  input  logic                                 rst,
  // setpoint[20:0], position[41:21], speed[57:42], climb_mode[59:58]
  input  logic [lcpsg_pkg::IN_DATA_W-1:0]      s_tdata,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // drive[14:0], direction[16:15], speed_target[37:17], stalled[38]
  output logic [lcpsg_pkg::OUT_DATA_W-1:0]     m_tdata,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  input  logic                                 cfg_wr_en,
  input  logic [lcpsg_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lcpsg_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
  import lcpsg_pkg::*;

  // scheduled gains can exceed 16 bits at large fraction widths (5.0 gain)
  localparam int SG_W   = (GAIN_FRAC_BITS + 3 > 16) ? GAIN_FRAC_BITS + 3 : 16;
  localparam int PROD_W = SG_W + 24;
  localparam int ACC_W  = SG_W + 26;

  localparam logic [SG_W-1:0] G_0P30 = SG_W'(((30  << GAIN_FRAC_BITS) + 50) / 100);
  localparam logic [SG_W-1:0] G_0P35 = SG_W'(((35  << GAIN_FRAC_BITS) + 50) / 100);
  localparam logic [SG_W-1:0] G_0P40 = SG_W'(((40  << GAIN_FRAC_BITS) + 50) / 100);
  localparam logic [SG_W-1:0] G_0P28 = SG_W'(((28  << GAIN_FRAC_BITS) + 50) / 100);
  localparam logic [SG_W-1:0] G_0P34 = SG_W'(((34  << GAIN_FRAC_BITS) + 50) / 100);
  localparam logic [SG_W-1:0] G_0P45 = SG_W'(((45  << GAIN_FRAC_BITS) + 50) / 100);
  localparam logic [SG_W-1:0] G_0P64 = SG_W'(((64  << GAIN_FRAC_BITS) + 50) / 100);
  localparam logic [SG_W-1:0] G_0P68 = SG_W'(((68  << GAIN_FRAC_BITS) + 50) / 100);
  localparam logic [SG_W-1:0] G_3P0  = SG_W'(((300 << GAIN_FRAC_BITS) + 50) / 100);
  localparam logic [SG_W-1:0] G_5P0  = SG_W'(((500 << GAIN_FRAC_BITS) + 50) / 100);
  localparam logic [SG_W-1:0] G_3P9  = SG_W'(((390 << GAIN_FRAC_BITS) + 50) / 100);

  localparam logic signed [ACC_W-1:0] Q_TGT_MAX   = ACC_W'(TGT_MAX);
  localparam logic signed [ACC_W-1:0] Q_TGT_MIN   = ACC_W'(TGT_MIN);
  localparam logic signed [ACC_W-1:0] Q_DRIVE_MAX = ACC_W'(DRIVE_LIM);
  localparam logic signed [ACC_W-1:0] Q_DRIVE_MIN = ACC_W'(-DRIVE_LIM);

  localparam logic [STALL_W:0] STALL_MAX = (STALL_W+1)'(STALL_TICKS);

  // sequencer codes
  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_ERR   = 5'd1;
  localparam logic [4:0] ST_OINT  = 5'd2;
  localparam logic [4:0] ST_OM0   = 5'd3;
  localparam logic [4:0] ST_OM1   = 5'd4;
  localparam logic [4:0] ST_OM2   = 5'd5;
  localparam logic [4:0] ST_OSUM  = 5'd6;
  localparam logic [4:0] ST_ODIV  = 5'd7;
  localparam logic [4:0] ST_SCHED = 5'd8;
  localparam logic [4:0] ST_SE    = 5'd9;
  localparam logic [4:0] ST_IINT  = 5'd10;
  localparam logic [4:0] ST_IM0   = 5'd11;
  localparam logic [4:0] ST_IM1   = 5'd12;
  localparam logic [4:0] ST_IM2   = 5'd13;
  localparam logic [4:0] ST_ISUM  = 5'd14;
  localparam logic [4:0] ST_IDIV  = 5'd15;
  localparam logic [4:0] ST_ISAT  = 5'd16;

  logic [4:0] state;

  // config registers
  logic [15:0]     outer_ki;
  logic [15:0]     outer_kd;
  logic [SG_W-1:0] inner_kp;

  // loop state
  logic signed [10:0] outer_integral;
  err_t               outer_prev_error;
  logic signed [13:0] inner_integral;
  err_t               inner_prev_error;
  logic [SG_W-1:0]    outer_kp_gain;
  logic [SG_W-1:0]    inner_ki_gain;
  logic [SG_W-1:0]    inner_kd_gain;
  logic [STALL_W-1:0] stall_count;

  // latched input word
  pos_t  sp_in;
  pos_t  pos_in;
  spd_t  spd_in;
  code_t mode_in;

  // working registers
  err_t                      e_r;
  code_t                     dir_r;
  diff_t                     d_r;      // derivative operand, both loops
  pos_t                      tgt_r;
  err_t                      se_r;
  logic signed [PROD_W-1:0]  prod;
  logic signed [ACC_W-1:0]   acc;
  logic signed [ACC_W-1:0]   q;

  // output register
  drive_t drive_o;
  code_t  dir_o;
  pos_t   tgt_o;
  logic   stalled_o;

  // ---- combinational helpers ----
  pos_t               sp_c;
  err_t               e_next;
  code_t              dir_next;
  logic signed [22:0] osum;
  logic signed [10:0] oint_next;
  logic signed [22:0] isum;
  logic signed [13:0] iint_next;
  logic signed [SG_W:0] mul_a;
  diff_t              mul_b;
  logic signed [ACC_W-1:0] q_next;
  logic [12:0]        lim;
  logic               has_lim;
  logic signed [ACC_W-1:0] lim_s;
  logic signed [ACC_W-1:0] clamp_hi;
  logic signed [ACC_W-1:0] clamp_lo;
  pos_t               tgt_next;
  spd_t               spd_dz;
  drive_t             drive_c;
  drive_t             drive_h;
  logic               stall_inc;
  logic [STALL_W:0]   cnt_inc;
  logic               hold;
  logic [STALL_W-1:0] cnt_next;
  logic               out_free;

  assign s_tready = (state == ST_IDLE);
  assign out_free = !m_tvalid || m_tready;
  assign m_tdata  = {1'b0, stalled_o, tgt_o, dir_o, drive_o};

  // setpoint clamp, position error, direction
  always_comb begin
    if (sp_in < SP_LO) begin
      sp_c = SP_LO;
    end else if (sp_in > SP_HI) begin
      sp_c = SP_HI;
    end else begin
      sp_c = sp_in;
    end
    e_next = 22'(sp_c) - 22'(pos_in);
    if (e_next > DIR_BAND) begin
      dir_next = DIR_UP;
    end else if (e_next < -DIR_BAND) begin
      dir_next = DIR_DOWN;
    end else begin
      dir_next = DIR_STOP;
    end
  end

  // integrators, saturating
  always_comb begin
    osum = 23'(outer_integral) + 23'(e_r);
    if (osum > OINT_LIM) begin
      oint_next = 11'(OINT_LIM);
    end else if (osum < -OINT_LIM) begin
      oint_next = 11'(-OINT_LIM);
    end else begin
      oint_next = osum[10:0];
    end
    isum = 23'(inner_integral) + 23'(se_r);
    if (isum > IINT_LIM) begin
      iint_next = 14'(IINT_LIM);
    end else if (isum < -IINT_LIM) begin
      iint_next = 14'(-IINT_LIM);
    end else begin
      iint_next = isum[13:0];
    end
  end

  // shared multiplier operand select
  always_comb begin
    case (state)
      ST_OM0: begin
        mul_a = $signed({1'b0, outer_kp_gain});
        mul_b = 23'(e_r);
      end
      ST_OM1: begin
        mul_a = $signed((SG_W+1)'(outer_ki));
        mul_b = 23'(outer_integral);
      end
      ST_OM2: begin
        mul_a = $signed((SG_W+1)'(outer_kd));
        mul_b = d_r;
      end
      ST_IM0: begin
        mul_a = $signed({1'b0, inner_kp});
        mul_b = 23'(se_r);
      end
      ST_IM1: begin
        mul_a = $signed({1'b0, inner_ki_gain});
        mul_b = 23'(inner_integral);
      end
      ST_IM2: begin
        mul_a = $signed({1'b0, inner_kd_gain});
        mul_b = d_r;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // divide by 2^F, truncating toward zero
  always_comb begin
    q_next = (acc + $signed({{(ACC_W-GAIN_FRAC_BITS){1'b0}},
                             {GAIN_FRAC_BITS{acc[ACC_W-1]}}})) >>> GAIN_FRAC_BITS;
  end

  // gain schedule target clamp
  always_comb begin
    lim     = '0;
    has_lim = 1'b0;
    case (dir_r)
      DIR_UP: begin
        if (mode_in == MODE_NORMAL) begin
          lim = LIM_UP_NORMAL;
          has_lim = 1'b1;
        end else if (mode_in == MODE_LOWERING) begin
          lim = LIM_UP_LOWERING;
          has_lim = 1'b1;
        end
      end
      DIR_DOWN: begin
        if (mode_in == MODE_NORMAL) begin
          lim = LIM_DN_NORMAL;
          has_lim = 1'b1;
        end else if (mode_in == MODE_RISING) begin
          lim = LIM_DN_RISING;
          has_lim = 1'b1;
        end
      end
      default: begin
        lim     = '0;
        has_lim = 1'b0;
      end
    endcase
    lim_s    = ACC_W'($signed({1'b0, lim}));
    clamp_hi = has_lim ? lim_s  : Q_TGT_MAX;
    clamp_lo = has_lim ? -lim_s : Q_TGT_MIN;
    if (q > clamp_hi) begin
      tgt_next = clamp_hi[20:0];
    end else if (q < clamp_lo) begin
      tgt_next = clamp_lo[20:0];
    end else begin
      tgt_next = q[20:0];
    end
  end

  // speed deadband
  always_comb begin
    if (spd_in <= DEADBAND && spd_in >= -DEADBAND) begin
      spd_dz = '0;
    end else begin
      spd_dz = spd_in;
    end
  end

  // drive saturation and stall guard
  always_comb begin
    if (q > Q_DRIVE_MAX) begin
      drive_c = Q_DRIVE_MAX[14:0];
    end else if (q < Q_DRIVE_MIN) begin
      drive_c = Q_DRIVE_MIN[14:0];
    end else begin
      drive_c = q[14:0];
    end
    stall_inc = (spd_in == '0) && (drive_c > STALL_DRIVE || drive_c < -STALL_DRIVE);
    cnt_inc   = {1'b0, stall_count} + (STALL_W+1)'(stall_inc);
    hold      = (cnt_inc >= STALL_MAX);
    cnt_next  = hold ? STALL_MAX[STALL_W-1:0] : cnt_inc[STALL_W-1:0];
    drive_h   = drive_c;
    if (hold) begin
      if (drive_c > STALL_DRIVE) begin
        drive_h = STALL_DRIVE;
      end else if (drive_c < -STALL_DRIVE) begin
        drive_h = -STALL_DRIVE;
      end
    end
    if (drive_h < STALL_DRIVE && drive_h > -STALL_DRIVE) begin
      cnt_next = '0;
    end
  end

  // config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      outer_ki <= '0;
      outer_kd <= '0;
      inner_kp <= G_3P9;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_OUTER_KI: outer_ki <= cfg_wdata;
        REG_OUTER_KD: outer_kd <= cfg_wdata;
        REG_INNER_KP: inner_kp <= SG_W'(cfg_wdata);
        default: ;
      endcase
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          sp_in   <= s_tdata[20:0];
          pos_in  <= s_tdata[41:21];
          spd_in  <= s_tdata[57:42];
          mode_in <= s_tdata[59:58];
        end
      end
      ST_ERR: begin
        e_r   <= e_next;
        dir_r <= dir_next;
      end
      ST_OINT:  d_r <= 23'(e_r) - 23'(outer_prev_error);
      ST_OM1:   acc <= ACC_W'(prod);
      ST_OM2:   acc <= acc + ACC_W'(prod);
      ST_OSUM:  acc <= acc + ACC_W'(prod);
      ST_ODIV:  q   <= q_next;
      ST_SCHED: tgt_r <= tgt_next;
      ST_SE:    se_r  <= 22'(tgt_r) - 22'(spd_dz);
      ST_IINT:  d_r <= 23'(se_r) - 23'(inner_prev_error);
      ST_IM1:   acc <= ACC_W'(prod);
      ST_IM2:   acc <= acc + ACC_W'(prod);
      ST_ISUM:  acc <= acc + ACC_W'(prod);
      ST_IDIV:  q   <= q_next;
      ST_ISAT: begin
        if (out_free) begin
          drive_o   <= drive_h;
          dir_o     <= dir_r;
          tgt_o     <= tgt_r;
          stalled_o <= hold;
        end
      end
      default: ;
    endcase
  end

  // sequencer and loop state
  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= ST_IDLE;
      m_tvalid         <= 1'b0;
      outer_integral   <= '0;
      outer_prev_error <= '0;
      inner_integral   <= '0;
      inner_prev_error <= '0;
      outer_kp_gain    <= G_0P30;
      inner_ki_gain    <= G_0P35;
      inner_kd_gain    <= '0;
      stall_count      <= '0;
    end else begin
      // in ISAT the output register handles its own valid flag
      if (m_tvalid && m_tready && state != ST_ISAT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_ERR;
          end
        end
        ST_OINT: begin
          outer_integral   <= oint_next;
          outer_prev_error <= e_r;
          state            <= ST_OM0;
        end
        ST_SCHED: begin
          case (dir_r)
            DIR_UP: begin
              if (mode_in == MODE_NORMAL) begin
                outer_kp_gain <= G_0P30;
                inner_ki_gain <= G_0P68;
                inner_kd_gain <= G_5P0;
              end else if (mode_in == MODE_LOWERING) begin
                inner_ki_gain <= G_0P28;
                inner_kd_gain <= G_5P0;
              end
            end
            DIR_DOWN: begin
              if (mode_in == MODE_NORMAL) begin
                outer_kp_gain <= G_0P30;
                inner_ki_gain <= G_0P34;
                inner_kd_gain <= G_5P0;
              end else if (mode_in == MODE_RISING) begin
                outer_kp_gain <= G_0P40;
                inner_ki_gain <= G_0P64;
                inner_kd_gain <= G_3P0;
              end
            end
            default: begin
              outer_kp_gain <= G_0P30;
              inner_ki_gain <= G_0P45;
            end
          endcase
          state <= ST_SE;
        end
        ST_IINT: begin
          inner_integral   <= iint_next;
          inner_prev_error <= se_r;
          state            <= ST_IM0;
        end
        ST_ISAT: begin
          // wait here while the previous result is still unclaimed
          if (out_free) begin
            stall_count <= cnt_next;
            m_tvalid    <= 1'b1;
            state       <= ST_IDLE;
          end
        end
        default: begin
          state <= state + 5'd1;
        end
      endcase
    end
  end

endmodule
